[rtl/core/pit_pkg.sv]
// Shared types and constants for the point-in-triangle test unit.
// Depends on nothing; every other file in rtl/core uses it by scoped name.
`default_nettype none

package pit_pkg;

  // Coordinate format: signed fixed point, three coordinates per register word.
  localparam int COORD_W = 16;
  localparam int REG_W   = 3 * COORD_W;
  localparam int TOL_W   = 32;
  localparam int IDX_W   = 3;

  // Exact widths of the intermediate values.
  localparam int DIFF_W  = COORD_W + 1;      // difference of two coordinates
  localparam int NPROD_W = 2 * COORD_W + 1;  // normal component times a difference
  localparam int EPROD_W = 2 * DIFF_W;       // product of two differences
  localparam int DOT_W   = 2 * COORD_W + 3;  // sum of three such products
  localparam int ABS_W   = DOT_W + 2;        // sum of three absolute dot products
  localparam int LO_W    = (DOT_W + 1) / 2;  // low half of a split dot product
  localparam int HI_W    = DOT_W - LO_W;     // signed high half
  localparam int PROD_W  = 2 * DOT_W;        // product of two dot products
  localparam int BARY_W  = PROD_W + 1;       // difference of two such products
  localparam int SUM_W   = BARY_W + 1;       // sum of two barycentric numerators

  localparam logic [TOL_W-1:0] TOL_RESET = 32'd17;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_VERTEX_A  = 3'd0,
    REG_VERTEX_B  = 3'd1,
    REG_VERTEX_C  = 3'd2,
    REG_NORMAL    = 3'd3,
    REG_TOLERANCE = 3'd4
  } reg_idx_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Input word: one query point.
  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
  } point_t;

  // Result word.
  typedef struct packed {
    logic inside_res;
    logic off_plane;
    logic degenerate;
  } result_t;

  // Dot products handed from the front end to the back end.
  typedef struct packed {
    logic signed [DOT_W-1:0] q0;
    logic signed [DOT_W-1:0] q1;
    logic signed [DOT_W-1:0] q2;
    logic signed [DOT_W-1:0] d02;
    logic signed [DOT_W-1:0] d12;
    logic signed [DOT_W-1:0] d00;
    logic signed [DOT_W-1:0] d01;
    logic signed [DOT_W-1:0] d11;
  } dots_t;

  // Extract coordinate idx (x lowest) from a packed register word.
  function automatic coord_t coord_of(input logic [REG_W-1:0] word, input int unsigned idx);
    return coord_t'(word[idx*COORD_W +: COORD_W]);
  endfunction

endpackage

`default_nettype wire

[rtl/core/pit_wmul.sv]
// Two-stage signed multiplier for dot products, split into four partial products.
// Depends on pit_pkg for the operand and product widths.
`default_nettype none

module pit_wmul (
  input  logic                                  clk,
  input  logic signed [pit_pkg::DOT_W-1:0]      a,
  input  logic signed [pit_pkg::DOT_W-1:0]      b,
  output logic signed [pit_pkg::PROD_W-1:0]     p
);

  localparam int LL_W = 2 * pit_pkg::LO_W;
  localparam int LH_W = pit_pkg::LO_W + 1 + pit_pkg::HI_W;
  localparam int HH_W = 2 * pit_pkg::HI_W;

  logic        [pit_pkg::LO_W-1:0] a_lo, b_lo;
  logic signed [pit_pkg::HI_W-1:0] a_hi, b_hi;

  logic        [LL_W-1:0]           ll_r;
  logic signed [LH_W-1:0]           lh_r, hl_r;
  logic signed [HH_W-1:0]           hh_r;
  logic signed [pit_pkg::PROD_W-1:0] p_r;

  // Unsigned low halves, signed high halves.
  assign a_lo = a[pit_pkg::LO_W-1:0];
  assign b_lo = b[pit_pkg::LO_W-1:0];
  assign a_hi = $signed(a[pit_pkg::DOT_W-1:pit_pkg::LO_W]);
  assign b_hi = $signed(b[pit_pkg::DOT_W-1:pit_pkg::LO_W]);

  // First stage: the four partial products.
  always_ff @(posedge clk) begin
    ll_r <= LL_W'(a_lo) * LL_W'(b_lo);
    lh_r <= LH_W'($signed({1'b0, a_lo})) * LH_W'(b_hi);
    hl_r <= LH_W'($signed({1'b0, b_lo})) * LH_W'(a_hi);
    hh_r <= HH_W'(a_hi) * HH_W'(b_hi);
  end

  // Second stage: shift and add the partial products.
  always_ff @(posedge clk) begin
    p_r <= (pit_pkg::PROD_W'(hh_r) <<< (2 * pit_pkg::LO_W))
         + ((pit_pkg::PROD_W'(lh_r) + pit_pkg::PROD_W'(hl_r)) <<< pit_pkg::LO_W)
         + pit_pkg::PROD_W'(ll_r);
  end

  assign p = p_r;

endmodule

`default_nettype wire

[rtl/core/pit_front.sv]
// Front end of the pipeline: coordinate differences, products and dot products.
// Also keeps the triangle's edge dot products. Depends on pit_pkg.
`default_nettype none

module pit_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  pit_pkg::point_t               in_point,
  input  logic [pit_pkg::REG_W-1:0]     vtx_a,
  input  logic [pit_pkg::REG_W-1:0]     vtx_b,
  input  logic [pit_pkg::REG_W-1:0]     vtx_c,
  input  logic [pit_pkg::REG_W-1:0]     normal,
  output logic                          out_valid,
  output pit_pkg::dots_t                out_dots
);

  pit_pkg::coord_t p [3];
  pit_pkg::coord_t va [3];
  pit_pkg::coord_t vb [3];
  pit_pkg::coord_t vc [3];
  pit_pkg::coord_t n [3];

  logic signed [pit_pkg::DIFF_W-1:0]  d_r  [3][3];
  logic signed [pit_pkg::NPROD_W-1:0] nq_r [3][3];
  logic signed [pit_pkg::EPROD_W-1:0] pe0_r [3];
  logic signed [pit_pkg::EPROD_W-1:0] pe1_r [3];
  logic signed [pit_pkg::DOT_W-1:0]   q_r [3];
  logic signed [pit_pkg::DOT_W-1:0]   d02_r, d12_r;

  logic signed [pit_pkg::DIFF_W-1:0]  e0_r [3];
  logic signed [pit_pkg::DIFF_W-1:0]  e1_r [3];
  logic signed [pit_pkg::EPROD_W-1:0] t00_r [3];
  logic signed [pit_pkg::EPROD_W-1:0] t01_r [3];
  logic signed [pit_pkg::EPROD_W-1:0] t11_r [3];
  logic signed [pit_pkg::DOT_W-1:0]   d00_r, d01_r, d11_r;

  logic v1_r, v2_r, v3_r;

  // Unpack the point and the configuration words.
  always_comb begin
    p[0] = in_point.point_x;
    p[1] = in_point.point_y;
    p[2] = in_point.point_z;
    for (int i = 0; i < 3; i++) begin
      va[i] = pit_pkg::coord_of(vtx_a, i);
      vb[i] = pit_pkg::coord_of(vtx_b, i);
      vc[i] = pit_pkg::coord_of(vtx_c, i);
      n[i]  = pit_pkg::coord_of(normal, i);
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage one: point minus each vertex.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      d_r[0][i] <= pit_pkg::DIFF_W'(p[i]) - pit_pkg::DIFF_W'(va[i]);
      d_r[1][i] <= pit_pkg::DIFF_W'(p[i]) - pit_pkg::DIFF_W'(vb[i]);
      d_r[2][i] <= pit_pkg::DIFF_W'(p[i]) - pit_pkg::DIFF_W'(vc[i]);
    end
  end

  // Stage two: per-component products for the plane distances and for the
  // point's dot products with both edges.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        nq_r[k][i] <= pit_pkg::NPROD_W'(n[i]) * pit_pkg::NPROD_W'(d_r[k][i]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      pe0_r[i] <= pit_pkg::EPROD_W'(e0_r[i]) * pit_pkg::EPROD_W'(d_r[0][i]);
      pe1_r[i] <= pit_pkg::EPROD_W'(e1_r[i]) * pit_pkg::EPROD_W'(d_r[0][i]);
    end
  end

  // Stage three: sum the components.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      q_r[k] <= pit_pkg::DOT_W'(nq_r[k][0]) + pit_pkg::DOT_W'(nq_r[k][1])
              + pit_pkg::DOT_W'(nq_r[k][2]);
    end
    d02_r <= pit_pkg::DOT_W'(pe0_r[0]) + pit_pkg::DOT_W'(pe0_r[1])
           + pit_pkg::DOT_W'(pe0_r[2]);
    d12_r <= pit_pkg::DOT_W'(pe1_r[0]) + pit_pkg::DOT_W'(pe1_r[1])
           + pit_pkg::DOT_W'(pe1_r[2]);
  end

  // Triangle side: the edge vectors and their dot products follow the same
  // three steps, so each value is current by the time a word reads it.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      e0_r[i]  <= pit_pkg::DIFF_W'(vc[i]) - pit_pkg::DIFF_W'(va[i]);
      e1_r[i]  <= pit_pkg::DIFF_W'(vb[i]) - pit_pkg::DIFF_W'(va[i]);
      t00_r[i] <= pit_pkg::EPROD_W'(e0_r[i]) * pit_pkg::EPROD_W'(e0_r[i]);
      t01_r[i] <= pit_pkg::EPROD_W'(e0_r[i]) * pit_pkg::EPROD_W'(e1_r[i]);
      t11_r[i] <= pit_pkg::EPROD_W'(e1_r[i]) * pit_pkg::EPROD_W'(e1_r[i]);
    end
    d00_r <= pit_pkg::DOT_W'(t00_r[0]) + pit_pkg::DOT_W'(t00_r[1])
           + pit_pkg::DOT_W'(t00_r[2]);
    d01_r <= pit_pkg::DOT_W'(t01_r[0]) + pit_pkg::DOT_W'(t01_r[1])
           + pit_pkg::DOT_W'(t01_r[2]);
    d11_r <= pit_pkg::DOT_W'(t11_r[0]) + pit_pkg::DOT_W'(t11_r[1])
           + pit_pkg::DOT_W'(t11_r[2]);
  end

  // Hand over to the back end.
  always_comb begin
    out_dots.q0  = q_r[0];
    out_dots.q1  = q_r[1];
    out_dots.q2  = q_r[2];
    out_dots.d02 = d02_r;
    out_dots.d12 = d12_r;
    out_dots.d00 = d00_r;
    out_dots.d01 = d01_r;
    out_dots.d11 = d11_r;
  end

  assign out_valid = v3_r;

endmodule

`default_nettype wire

[rtl/core/pit_back.sv]
// Back end of the pipeline: plane distance check, barycentric numerators and
// denominator, sign-aware compares and the result register. Depends on pit_pkg, pit_wmul.
`default_nettype none

module pit_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  pit_pkg::dots_t                in_dots,
  input  logic [pit_pkg::TOL_W-1:0]     tol,
  output logic                          out_valid,
  output pit_pkg::result_t              out_result
);

  logic [pit_pkg::DOT_W-1:0] qa0, qa1, qa2;
  logic [pit_pkg::ABS_W-1:0] abs_sum_r;

  logic signed [pit_pkg::PROD_W-1:0] den_p1, den_p2, un_p1, un_p2, vn_p1, vn_p2;
  logic signed [pit_pkg::BARY_W-1:0] den_r, un_r, vn_r;

  logic signed [pit_pkg::SUM_W-1:0] s_sum, den_ext;
  logic den_zero, un_le0, vn_le0, in_tri;

  logic v4_r, v5_r, v6_r, v7_r;
  logic off5_r, off6_r;
  pit_pkg::result_t res_r;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      v4_r <= in_valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  // Stage four: absolute plane distances, summed.
  always_comb begin
    qa0 = in_dots.q0[pit_pkg::DOT_W-1] ? pit_pkg::DOT_W'(-in_dots.q0) : in_dots.q0;
    qa1 = in_dots.q1[pit_pkg::DOT_W-1] ? pit_pkg::DOT_W'(-in_dots.q1) : in_dots.q1;
    qa2 = in_dots.q2[pit_pkg::DOT_W-1] ? pit_pkg::DOT_W'(-in_dots.q2) : in_dots.q2;
  end

  always_ff @(posedge clk) begin
    abs_sum_r <= pit_pkg::ABS_W'(qa0) + pit_pkg::ABS_W'(qa1) + pit_pkg::ABS_W'(qa2);
  end

  // Stages four and five: the six wide products.
  pit_wmul u_mul_den1 (.clk(clk), .a(in_dots.d00), .b(in_dots.d11), .p(den_p1));
  pit_wmul u_mul_den2 (.clk(clk), .a(in_dots.d01), .b(in_dots.d01), .p(den_p2));
  pit_wmul u_mul_un1  (.clk(clk), .a(in_dots.d11), .b(in_dots.d02), .p(un_p1));
  pit_wmul u_mul_un2  (.clk(clk), .a(in_dots.d01), .b(in_dots.d12), .p(un_p2));
  pit_wmul u_mul_vn1  (.clk(clk), .a(in_dots.d00), .b(in_dots.d12), .p(vn_p1));
  pit_wmul u_mul_vn2  (.clk(clk), .a(in_dots.d01), .b(in_dots.d02), .p(vn_p2));

  // Stage five: tolerance compare, alongside the products.
  always_ff @(posedge clk) begin
    off5_r <= abs_sum_r > pit_pkg::ABS_W'(tol);
  end

  // Stage six: denominator and numerators.
  always_ff @(posedge clk) begin
    den_r  <= pit_pkg::BARY_W'(den_p1) - pit_pkg::BARY_W'(den_p2);
    un_r   <= pit_pkg::BARY_W'(un_p1) - pit_pkg::BARY_W'(un_p2);
    vn_r   <= pit_pkg::BARY_W'(vn_p1) - pit_pkg::BARY_W'(vn_p2);
    off6_r <= off5_r;
  end

  // Stage seven: u >= 0, v >= 0 and u + v < 1 without a division. With a
  // negative denominator every compare is mirrored.
  always_comb begin
    s_sum    = pit_pkg::SUM_W'(un_r) + pit_pkg::SUM_W'(vn_r);
    den_ext  = pit_pkg::SUM_W'(den_r);
    den_zero = (den_r == '0);
    un_le0   = un_r[pit_pkg::BARY_W-1] || (un_r == '0);
    vn_le0   = vn_r[pit_pkg::BARY_W-1] || (vn_r == '0);
    if (!den_r[pit_pkg::BARY_W-1]) begin
      in_tri = !un_r[pit_pkg::BARY_W-1] && !vn_r[pit_pkg::BARY_W-1] && (s_sum < den_ext);
    end else begin
      in_tri = un_le0 && vn_le0 && (den_ext < s_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (off6_r) begin
      res_r.inside_res <= 1'b0;
      res_r.off_plane  <= 1'b1;
      res_r.degenerate <= 1'b0;
    end else if (den_zero) begin
      res_r.inside_res <= 1'b0;
      res_r.off_plane  <= 1'b0;
      res_r.degenerate <= 1'b1;
    end else begin
      res_r.inside_res <= in_tri;
      res_r.off_plane  <= 1'b0;
      res_r.degenerate <= 1'b0;
    end
  end

  assign out_valid  = v7_r;
  assign out_result = res_r;

endmodule

`default_nettype wire

[rtl/core/point_in_triangle_test_unit.sv]
// Point-in-triangle test unit: one query word per cycle against a loaded triangle.
// Results: a word accepted at a clock edge passes the seven register stages and shows its
// result with out_strobe for one cycle.
// Throughput: one word per cycle; busy is high only while reset is held, so a word
// may follow in the next cycle. Results cannot be stalled by the receiver.
// Reset (synchronous, rst_n low) clears the valid bits, vertices and normal to zero
// and the tolerance to 17. Depends on pit_pkg, pit_front, pit_back, pit_wmul.
`default_nettype none

module point_in_triangle_test_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  pit_pkg::point_t                 in_point,
  output logic                            out_strobe,
  output pit_pkg::result_t                out_result,
  input  logic                            cfg_we,
  input  logic [pit_pkg::IDX_W-1:0]       cfg_index,
  input  logic [pit_pkg::REG_W-1:0]       cfg_wdata
);

  logic [pit_pkg::REG_W-1:0] vtx_a_r, vtx_b_r, vtx_c_r, normal_r;
  logic [pit_pkg::TOL_W-1:0] tol_r;
  logic                      busy_r;
  logic                      accept;
  logic                      dots_valid;
  pit_pkg::dots_t            dots;

  // Busy only while held in reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vtx_a_r  <= '0;
      vtx_b_r  <= '0;
      vtx_c_r  <= '0;
      normal_r <= '0;
      tol_r    <= pit_pkg::TOL_RESET;
    end else if (cfg_we) begin
      unique case (pit_pkg::reg_idx_t'(cfg_index))
        pit_pkg::REG_VERTEX_A:  vtx_a_r  <= cfg_wdata;
        pit_pkg::REG_VERTEX_B:  vtx_b_r  <= cfg_wdata;
        pit_pkg::REG_VERTEX_C:  vtx_c_r  <= cfg_wdata;
        pit_pkg::REG_NORMAL:    normal_r <= cfg_wdata;
        pit_pkg::REG_TOLERANCE: tol_r    <= cfg_wdata[pit_pkg::TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Dot product stages.
  pit_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_point  (in_point),
    .vtx_a     (vtx_a_r),
    .vtx_b     (vtx_b_r),
    .vtx_c     (vtx_c_r),
    .normal    (normal_r),
    .out_valid (dots_valid),
    .out_dots  (dots)
  );

  // Plane check, barycentric compares and result register.
  pit_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (dots_valid),
    .in_dots    (dots),
    .tol        (tol_r),
    .out_valid  (out_strobe),
    .out_result (out_result)
  );

  // Every accepted word produces a result at the end of the pipeline.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##7 out_strobe)
    else $error("accepted word produced no result");

  // No result appears without a matching accepted word.
  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, 7))
    else $error("result without a matching accepted word");

  // An off-plane result never claims inside or degenerate.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result.off_plane) |-> (!out_result.inside_res && !out_result.degenerate))
    else $error("off-plane result carries other flags");

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for point_in_triangle_test_unit: it loads triangles,
// streams query words and compares every result word with an exact-integer predictor.
// Depends on pit_pkg and point_in_triangle_test_unit.
module tb;
  import pit_pkg::*;

  // Pipeline depth of the unit, used when waiting for it to drain.
  localparam int RESULT_LATENCY = 7;
  localparam int STALL_LIMIT    = 2000;
  localparam int PRINT_CAP      = 50;

  typedef logic signed [127:0] exact_t;

  typedef struct {
    point_t  pt;
    result_t want;
  } verdict_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  point_t               in_point = '0;
  logic                 out_strobe;
  result_t              out_result;
  logic                 cfg_we = 1'b0;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [REG_W-1:0]     cfg_wdata = '0;

  // Predictor copy of the triangle registers.
  logic [REG_W-1:0]     tri_vertex [3];
  logic [REG_W-1:0]     tri_normal;
  logic [TOL_W-1:0]     tri_tolerance;

  verdict_t             pending_verdicts [$];
  verdict_t             oldest_verdict;
  int                   mismatch_count = 0;
  int                   idle_pct = 0;
  int                   quiet_cycles = 0;

  point_in_triangle_test_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_point   (in_point),
    .out_strobe (out_strobe),
    .out_result (out_result),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Helpers for building words.
  function automatic logic [REG_W-1:0] pack_xyz(input int x, input int y, input int z);
    return {coord_t'(z), coord_t'(y), coord_t'(x)};
  endfunction

  function automatic point_t make_point(input int x, input int y, input int z);
    point_t pt;
    pt.point_x = coord_t'(x);
    pt.point_y = coord_t'(y);
    pt.point_z = coord_t'(z);
    return pt;
  endfunction

  function automatic logic [REG_W-1:0] random_word();
    return {16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  function automatic logic [TOL_W-1:0] random_tolerance();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return TOL_W'($urandom_range(0, 2000));
      2: return TOL_W'($urandom);
      default: return '1;
    endcase
  endfunction

  function automatic exact_t coord_at(input logic [REG_W-1:0] word, input int idx);
    coord_t c;
    c = word[idx*COORD_W +: COORD_W];
    return c;
  endfunction

  // Exact prediction: plane distance and degenerate checks, then division-free barycentric compares.
  function automatic result_t classify_point(input point_t pt);
    exact_t  p [3];
    exact_t  n [3];
    exact_t  vx [3][3];
    exact_t  e0 [3];
    exact_t  e1 [3];
    exact_t  e2 [3];
    exact_t  plane_dist, dist_sum, tol, d00, d01, d02, d11, d12, den, un, vn, uv;
    result_t r;
    p[0] = pt.point_x;
    p[1] = pt.point_y;
    p[2] = pt.point_z;
    for (int i = 0; i < 3; i++) begin
      n[i] = coord_at(tri_normal, i);
      for (int k = 0; k < 3; k++) vx[k][i] = coord_at(tri_vertex[k], i);
    end
    tol = tri_tolerance;
    r = '0;

    // Sum of absolute plane distances measured from each vertex.
    dist_sum = 0;
    for (int k = 0; k < 3; k++) begin
      plane_dist = 0;
      for (int i = 0; i < 3; i++) plane_dist += n[i] * (p[i] - vx[k][i]);
      dist_sum += (plane_dist < 0) ? -plane_dist : plane_dist;
    end
    if (dist_sum > tol) begin
      r.off_plane = 1'b1;
      return r;
    end

    d00 = 0; d01 = 0; d02 = 0; d11 = 0; d12 = 0;
    for (int i = 0; i < 3; i++) begin
      e0[i] = vx[2][i] - vx[0][i];
      e1[i] = vx[1][i] - vx[0][i];
      e2[i] = p[i] - vx[0][i];
      d00 += e0[i] * e0[i];
      d01 += e0[i] * e1[i];
      d02 += e0[i] * e2[i];
      d11 += e1[i] * e1[i];
      d12 += e1[i] * e2[i];
    end
    den = d00 * d11 - d01 * d01;
    if (den == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    un = d11 * d02 - d01 * d12;
    vn = d00 * d12 - d01 * d02;
    uv = un + vn;
    // A negative denominator mirrors every compare, as a true division would.
    if (den > 0) r.inside_res = (un >= 0) && (vn >= 0) && (uv < den);
    else         r.inside_res = (un <= 0) && (vn <= 0) && (uv > den);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic check_field(input verdict_t v, input string field, input logic got,
                             input logic want);
    if (got !== want)
      report_mismatch($sformatf("point (%0d,%0d,%0d) %s got %b want %b",
                                v.pt.point_x, v.pt.point_y, v.pt.point_z, field, got, want));
  endtask

  // Register write while the unit is idle; the enable stays high for one cycle.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_VERTEX_A:  tri_vertex[0] = data;
      REG_VERTEX_B:  tri_vertex[1] = data;
      REG_VERTEX_C:  tri_vertex[2] = data;
      REG_NORMAL:    tri_normal = data;
      REG_TOLERANCE: tri_tolerance = data[TOL_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_triangle(input logic [REG_W-1:0] va, input logic [REG_W-1:0] vb,
                               input logic [REG_W-1:0] vc, input logic [REG_W-1:0] nrm,
                               input logic [TOL_W-1:0] tol);
    write_reg(REG_VERTEX_A, va);
    write_reg(REG_VERTEX_B, vb);
    write_reg(REG_VERTEX_C, vc);
    write_reg(REG_NORMAL, nrm);
    // Upper write-data bits carry junk that the tolerance register must drop.
    write_reg(REG_TOLERANCE, {16'($urandom), tol});
  endtask

  // Send one query word, idling first at the current rate, and record its verdict.
  task automatic send_point(input point_t pt);
    verdict_t v;
    while (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      start    <= 1'b0;
      in_point <= {16'($urandom), 16'($urandom), 16'($urandom)};
      @(posedge clk);
    end
    start    <= 1'b1;
    in_point <= pt;
    @(posedge clk);
    while (busy) @(posedge clk);
    v.pt   = pt;
    v.want = classify_point(pt);
    pending_verdicts.push_back(v);
  endtask

  // Hold off until every pending result word is back and the pipeline has drained.
  task automatic settle();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  // Reset state: all-zero triangle and normal, so every point is degenerate.
  task automatic test_reset_state();
    idle_pct = 0;
    send_point(make_point(32767, -32768, 0));
    send_point(make_point(-32768, 32767, -1));
    send_point(make_point(0, 0, 0));
    settle();
  endtask

  // Writes to indexes past the register list must leave every register alone.
  task automatic test_stray_index();
    for (int s = int'(REG_TOLERANCE) + 1; s < (1 << IDX_W); s++)
      write_reg(IDX_W'(s), random_word());
    send_point(make_point(1234, -4321, 77));
    send_point(make_point(-1, -1, -1));
    settle();
  endtask

  // Unit right triangle in the z=0 plane: interior, vertices, edges, outside and off the plane.
  task automatic test_unit_triangle();
    load_triangle(pack_xyz(0, 0, 0), pack_xyz(4096, 0, 0), pack_xyz(0, 4096, 0),
                  pack_xyz(0, 0, 4096), TOL_RESET);
    send_point(make_point(1024, 1024, 0));
    send_point(make_point(0, 0, 0));
    send_point(make_point(4096, 0, 0));
    send_point(make_point(2048, 2048, 0));
    send_point(make_point(2047, 2048, 0));
    send_point(make_point(-1, 100, 0));
    send_point(make_point(1000, 1000, 1));
    settle();
  endtask

  // Summed distance exactly at the tolerance stays on the plane, one above does not.
  task automatic test_tolerance_edge();
    load_triangle(pack_xyz(0, 0, 0), pack_xyz(4096, 0, 0), pack_xyz(0, 4096, 0),
                  pack_xyz(0, 0, 1), 32'd3);
    send_point(make_point(100, 100, 1));
    settle();
    write_reg(REG_TOLERANCE, {16'($urandom), 32'd2});
    send_point(make_point(100, 100, 1));
    settle();
    write_reg(REG_TOLERANCE, '0);
    send_point(make_point(100, 100, 0));
    settle();
  endtask

  // Full-scale coordinates, normal and tolerance; then a collinear triangle.
  task automatic test_extremes();
    load_triangle(pack_xyz(32767, 32767, 32767), pack_xyz(-32768, -32768, -32768),
                  pack_xyz(32767, -32768, 0), pack_xyz(-32768, -32768, -32768), '1);
    send_point(make_point(32767, 32767, 32767));
    send_point(make_point(-32768, -32768, -32768));
    settle();
    write_reg(REG_NORMAL, '0);
    write_reg(REG_TOLERANCE, '0);
    send_point(make_point(32767, -32768, 32767));
    send_point(make_point(0, 0, 0));
    settle();
    load_triangle(pack_xyz(0, 0, 0), pack_xyz(100, 100, 100), pack_xyz(200, 200, 200),
                  '0, TOL_RESET);
    send_point(make_point(50, 50, 50));
    settle();
  endtask

  // Triangles built on a small lattice so that queries land on the plane, near edges
  // and around the interior; a share of queries is jittered off the plane, and some are random words.
  task automatic test_planar_triangles();
    int f0 [3];
    int f1 [3];
    int a [3];
    int nrm [3];
    int p [3];
    int span, scale, i, j;
    for (int t = 0; t < 24; t++) begin
      idle_pct = (t % 3 == 0) ? 0 : (t % 3 == 1) ? 77 : 6;
      for (int k = 0; k < 3; k++) begin
        a[k]  = $urandom_range(0, 16000) - 8000;
        f0[k] = $urandom_range(0, 30) - 15;
        f1[k] = $urandom_range(0, 30) - 15;
      end
      // Now and then a flat triangle with parallel edges.
      if ($urandom_range(0, 7) == 0)
        for (int k = 0; k < 3; k++) f1[k] = ($urandom_range(0, 1) != 0) ? -f0[k] : 2 * f0[k];
      span  = $urandom_range(1, 200);
      scale = $urandom_range(1, 4);
      if ($urandom_range(0, 1) != 0) scale = -scale;
      nrm[0] = scale * (f0[1] * f1[2] - f0[2] * f1[1]);
      nrm[1] = scale * (f0[2] * f1[0] - f0[0] * f1[2]);
      nrm[2] = scale * (f0[0] * f1[1] - f0[1] * f1[0]);
      load_triangle(pack_xyz(a[0], a[1], a[2]),
                    pack_xyz(a[0] + span * f1[0], a[1] + span * f1[1], a[2] + span * f1[2]),
                    pack_xyz(a[0] + span * f0[0], a[1] + span * f0[1], a[2] + span * f0[2]),
                    pack_xyz(nrm[0], nrm[1], nrm[2]), random_tolerance());
      for (int q = 0; q < 40; q++) begin
        i = $urandom_range(0, span + span / 2) - span / 4;
        j = $urandom_range(0, span + span / 2) - span / 4;
        for (int k = 0; k < 3; k++) begin
          p[k] = a[k] + i * f0[k] + j * f1[k];
          if ($urandom_range(0, 3) == 0) p[k] += $urandom_range(0, 6) - 3;
        end
        if ($urandom_range(0, 9) == 0) send_point(random_word());
        else send_point(make_point(p[0], p[1], p[2]));
      end
      settle();
    end
  endtask

  // Unstructured triangles and points over the full field ranges.
  task automatic test_random_noise();
    logic [REG_W-1:0] nrm;
    for (int t = 0; t < 12; t++) begin
      idle_pct = (t % 2 == 0) ? 77 : 0;
      case ($urandom_range(0, 2))
        0: nrm = '0;
        1: nrm = pack_xyz($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
                          $urandom_range(0, 8) - 4);
        default: nrm = random_word();
      endcase
      load_triangle(random_word(), random_word(), random_word(), nrm, random_tolerance());
      for (int q = 0; q < 40; q++) send_point(random_word());
      settle();
    end
  endtask

  // Result checker: every strobed word is matched against the oldest verdict.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result word arrived with no query pending");
      end else begin
        oldest_verdict = pending_verdicts.pop_front();
        check_field(oldest_verdict, "inside_res", out_result.inside_res,
                    oldest_verdict.want.inside_res);
        check_field(oldest_verdict, "off_plane", out_result.off_plane,
                    oldest_verdict.want.off_plane);
        check_field(oldest_verdict, "degenerate", out_result.degenerate,
                    oldest_verdict.want.degenerate);
      end
    end
  end

  // Watchdog: ends the run when no word moves in either direction for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TIMEOUT: no word accepted for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    tri_vertex[0] = '0;
    tri_vertex[1] = '0;
    tri_vertex[2] = '0;
    tri_normal    = '0;
    tri_tolerance = TOL_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_stray_index();
    test_unit_triangle();
    test_tolerance_edge();
    test_extremes();
    test_planar_triangles();
    test_random_noise();
    settle();

    if (pending_verdicts.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_verdicts.size()));
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
